FILE: hdl/aarm_pkg.sv
// Package for the axis-angle rotation matrix block: fixed-point widths,
// payload structs, the CORDIC arctangent table and rounding helpers.
// No dependencies.
`default_nettype none

package aarm_pkg;

  // Fixed-point format of axis components and matrix entries
  localparam int FracBits    = 14;
  localparam int AxW         = 16;

  // Angle reduction: 1/64 degree units
  localparam int FullTurn    = 23040;
  localparam int QuarterTurn = 5760;
  localparam int RemW        = 13;
  localparam int AngleMulK   = 9370165;   // 1/64 degree to Q30 radians, times 32
  localparam int AngleMulW   = 24;

  // CORDIC in Q30
  localparam int CordicIters = 24;
  localparam int CordicW     = 34;
  localparam int ZW          = 33;
  localparam int CordicGain  = 652032874;
  localparam int CsSh        = 30 - FracBits;

  // Datapath widths of the matrix stage
  localparam int CsW   = FracBits + 3;
  localparam int PqW   = 2 * AxW;
  localparam int WsW   = AxW + CsW;
  localparam int PqoW  = PqW + CsW;
  localparam int TW    = PqoW + 2;

  localparam logic signed [CsW-1:0] OneC  = CsW'(1) <<< FracBits;
  localparam logic signed [TW-1:0]  HalfT = TW'(1) <<< (FracBits - 1);

  // Queue depths
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int ODepth = 2;

  localparam logic signed [TW-1:0] SatMax = TW'(32767);
  localparam logic signed [TW-1:0] SatMin = -TW'(32768);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [AxW-1:0] axis_x;
    logic signed [AxW-1:0] axis_y;
    logic signed [AxW-1:0] axis_z;
    logic signed [AxW-1:0] angle_deg;
  } item_t;

  typedef struct packed {
    logic signed [AxW-1:0] m00;
    logic signed [AxW-1:0] m10;
    logic signed [AxW-1:0] m20;
    logic signed [AxW-1:0] m01;
    logic signed [AxW-1:0] m11;
    logic signed [AxW-1:0] m21;
    logic signed [AxW-1:0] m02;
    logic signed [AxW-1:0] m12;
    logic signed [AxW-1:0] m22;
  } result_t;

  // Classified item between front and back
  typedef struct packed {
    logic signed [AxW-1:0] axis_x;
    logic signed [AxW-1:0] axis_y;
    logic signed [AxW-1:0] axis_z;
    quad_e                 quad;
    logic [RemW-1:0]       rem;
  } entry_t;

  // Cosine and sine with the axis, out of the CORDIC
  typedef struct packed {
    logic signed [AxW-1:0] axis_x;
    logic signed [AxW-1:0] axis_y;
    logic signed [AxW-1:0] axis_z;
    logic signed [CsW-1:0] c;
    logic signed [CsW-1:0] s;
  } cs_t;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_f(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd843314857;
      1:       v = 32'd497837829;
      2:       v = 32'd263043837;
      3:       v = 32'd133525159;
      4:       v = 32'd67021687;
      5:       v = 32'd33543516;
      6:       v = 32'd16775851;
      7:       v = 32'd8388437;
      8:       v = 32'd4194283;
      9:       v = 32'd2097149;
      default: v = 32'd1 << (30 - i);
    endcase
    return v;
  endfunction

  // Round half up by FracBits
  function automatic logic signed [TW-1:0] rnd_f(input logic signed [TW-1:0] v);
    return (v + HalfT) >>> FracBits;
  endfunction

  function automatic logic signed [AxW-1:0] sat_f(input logic signed [TW-1:0] v);
    logic signed [AxW-1:0] r;
    if (v > SatMax) begin
      r = AxW'(SatMax);
    end else if (v < SatMin) begin
      r = AxW'(SatMin);
    end else begin
      r = v[AxW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/aarm_front.sv
// Front end: accepts items, reduces the angle to quadrant and remainder,
// and holds classified items in a short queue. Depends on aarm_pkg.
`default_nettype none

module aarm_front import aarm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push,
  output logic        full,
  input  wire item_t  item_i,
  input  wire logic   take_i,
  output logic        valid_o,
  output entry_t      entry_o
);

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QPtrW:0]     cnt_q;
  logic signed [16:0] ang_w;
  logic signed [16:0] red_w;
  logic [14:0]        a_w;
  entry_t             ent_w;
  logic               wr_en, rd_en;

  // Angle modulo a full turn, into [0, FullTurn)
  always_comb begin
    ang_w = 17'(item_i.angle_deg);
    if (ang_w < -17'sd23040) begin
      red_w = ang_w + 17'(2 * FullTurn);
    end else if (ang_w < 17'sd0) begin
      red_w = ang_w + 17'(FullTurn);
    end else if (ang_w >= 17'sd23040) begin
      red_w = ang_w - 17'(FullTurn);
    end else begin
      red_w = ang_w;
    end
    a_w = red_w[14:0];
  end

  // Quadrant and remainder
  always_comb begin
    ent_w.axis_x = item_i.axis_x;
    ent_w.axis_y = item_i.axis_y;
    ent_w.axis_z = item_i.axis_z;
    if (a_w >= 15'(3 * QuarterTurn)) begin
      ent_w.quad = QUAD_3;
      ent_w.rem  = RemW'(a_w - 15'(3 * QuarterTurn));
    end else if (a_w >= 15'(2 * QuarterTurn)) begin
      ent_w.quad = QUAD_2;
      ent_w.rem  = RemW'(a_w - 15'(2 * QuarterTurn));
    end else if (a_w >= 15'(QuarterTurn)) begin
      ent_w.quad = QUAD_1;
      ent_w.rem  = RemW'(a_w - 15'(QuarterTurn));
    end else begin
      ent_w.quad = QUAD_0;
      ent_w.rem  = RemW'(a_w);
    end
  end

  assign full    = (cnt_q == (QPtrW+1)'(QDepth));
  assign wr_en   = push && !full;
  assign valid_o = (cnt_q != '0);
  assign rd_en   = take_i && valid_o;
  assign entry_o = mem_q[rd_q];

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en && rd_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= ent_w;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth))
    else $error("front queue count out of range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ent_w.rem < RemW'(QuarterTurn))
    else $error("angle remainder not below a quarter turn");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("front queue count lost a transfer");

endmodule

`default_nettype wire

FILE: hdl/aarm_cordic.sv
// Pipelined CORDIC: one Q30 rotation per stage, then quadrant fold and
// rounding of cosine and sine to the output format. Depends on aarm_pkg.
`default_nettype none

module aarm_cordic import aarm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  wire entry_t entry_i,
  output logic        valid_o,
  output cs_t         cs_o
);

  logic                      v_q [CordicIters+2];
  entry_t                    e_q [CordicIters+1];
  logic signed [CordicW-1:0] x_q [CordicIters+1];
  logic signed [CordicW-1:0] y_q [CordicIters+1];
  logic signed [ZW-1:0]      z_q [CordicIters+1];
  cs_t                       cs_q;

  logic [RemW+AngleMulW-1:0] zprod_w;
  logic [ZW-1:0]             z0_w;
  logic signed [CordicW-1:0] cq_w, sq_w, cr_w, sr_w;

  // Remainder to Q30 radians
  always_comb begin
    zprod_w = (RemW+AngleMulW)'(entry_i.rem) * (RemW+AngleMulW)'(AngleMulK);
    zprod_w = zprod_w + (RemW+AngleMulW)'(16);
    z0_w    = ZW'(zprod_w >> 5);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CordicIters + 2; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < CordicIters + 2; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // Load stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0] <= entry_i;
      x_q[0] <= CordicW'(CordicGain);
      y_q[0] <= '0;
      z_q[0] <= z0_w;
    end
  end

  // Rotation stages
  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[i+1] <= e_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ZW'(atan_f(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ZW'(atan_f(i));
        end
      end
    end
  end

  // Quadrant fold
  always_comb begin
    case (e_q[CordicIters].quad)
      QUAD_1: begin
        cq_w = -y_q[CordicIters];
        sq_w = x_q[CordicIters];
      end
      QUAD_2: begin
        cq_w = -x_q[CordicIters];
        sq_w = -y_q[CordicIters];
      end
      QUAD_3: begin
        cq_w = y_q[CordicIters];
        sq_w = -x_q[CordicIters];
      end
      default: begin
        cq_w = x_q[CordicIters];
        sq_w = y_q[CordicIters];
      end
    endcase
  end

  // Round half up from Q30
  always_comb begin
    if (CsSh == 0) begin
      cr_w = cq_w;
      sr_w = sq_w;
    end else begin
      cr_w = (cq_w + (CordicW'(1) <<< (CsSh - 1))) >>> CsSh;
      sr_w = (sq_w + (CordicW'(1) <<< (CsSh - 1))) >>> CsSh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q.axis_x <= e_q[CordicIters].axis_x;
      cs_q.axis_y <= e_q[CordicIters].axis_y;
      cs_q.axis_z <= e_q[CordicIters].axis_z;
      cs_q.c      <= cr_w[CsW-1:0];
      cs_q.s      <= sr_w[CsW-1:0];
    end
  end

  assign valid_o = v_q[CordicIters+1];
  assign cs_o    = cs_q;

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cs_q.c <= OneC) && (cs_q.c >= -OneC))
    else $error("cosine beyond unit range");

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cs_q.s <= OneC) && (cs_q.s >= -OneC))
    else $error("sine beyond unit range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

FILE: hdl/aarm_matrix.sv
// Back end: products, Rodrigues sums, rounding and saturation of the nine
// entries, and the result queue. Depends on aarm_pkg.
`default_nettype none

module aarm_matrix import aarm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire cs_t   cs_i,
  output logic       en_o,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result_o
);

  logic                   v_q [3];

  // Stage 1: axis products and w*s
  logic signed [PqW-1:0]  pq1_q [6];
  logic signed [WsW-1:0]  ws1_q [3];
  logic signed [CsW-1:0]  c1_q, omc1_q;
  // Stage 2: times (1-c)
  logic signed [PqoW-1:0] pqo2_q [6];
  logic signed [WsW-1:0]  ws2_q [3];
  logic signed [CsW-1:0]  c2_q;
  // Stage 3: sums before final rounding
  logic signed [TW-1:0]   t3_q [9];

  logic signed [TW-1:0]   pr_w [6];
  logic signed [TW-1:0]   wx_w, wy_w, wz_w, cc_w;
  result_t                res_w;

  result_t                mem_q [ODepth];
  logic                   wr_q, rd_q;
  logic [1:0]             cnt_q;
  logic                   wr_en, rd_en;

  assign en_o = (cnt_q != 2'(ODepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_o) begin
      v_q[0] <= valid_i;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
    end
  end

  // Products: xx yy zz xy xz yz, and x*s y*s z*s
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      pq1_q[0] <= PqW'(cs_i.axis_x) * PqW'(cs_i.axis_x);
      pq1_q[1] <= PqW'(cs_i.axis_y) * PqW'(cs_i.axis_y);
      pq1_q[2] <= PqW'(cs_i.axis_z) * PqW'(cs_i.axis_z);
      pq1_q[3] <= PqW'(cs_i.axis_x) * PqW'(cs_i.axis_y);
      pq1_q[4] <= PqW'(cs_i.axis_x) * PqW'(cs_i.axis_z);
      pq1_q[5] <= PqW'(cs_i.axis_y) * PqW'(cs_i.axis_z);
      ws1_q[0] <= WsW'(cs_i.axis_x) * WsW'(cs_i.s);
      ws1_q[1] <= WsW'(cs_i.axis_y) * WsW'(cs_i.s);
      ws1_q[2] <= WsW'(cs_i.axis_z) * WsW'(cs_i.s);
      c1_q     <= cs_i.c;
      omc1_q   <= OneC - cs_i.c;
    end
  end

  // Scale by (1-c)
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int k = 0; k < 6; k++) begin
        pqo2_q[k] <= PqoW'(pq1_q[k]) * PqoW'(omc1_q);
      end
      for (int k = 0; k < 3; k++) begin
        ws2_q[k] <= ws1_q[k];
      end
      c2_q <= c1_q;
    end
  end

  // Round products, add skew and diagonal terms
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pr_w[k] = rnd_f(TW'(pqo2_q[k]));
    end
    wx_w = TW'(ws2_q[0]);
    wy_w = TW'(ws2_q[1]);
    wz_w = TW'(ws2_q[2]);
    cc_w = TW'(c2_q) <<< FracBits;
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      t3_q[0] <= pr_w[0] + cc_w;
      t3_q[1] <= pr_w[3] + wz_w;
      t3_q[2] <= pr_w[4] - wy_w;
      t3_q[3] <= pr_w[3] - wz_w;
      t3_q[4] <= pr_w[1] + cc_w;
      t3_q[5] <= pr_w[5] + wx_w;
      t3_q[6] <= pr_w[4] + wy_w;
      t3_q[7] <= pr_w[5] - wx_w;
      t3_q[8] <= pr_w[2] + cc_w;
    end
  end

  // Final rounding and saturation
  always_comb begin
    res_w.m00 = sat_f(rnd_f(t3_q[0]));
    res_w.m10 = sat_f(rnd_f(t3_q[1]));
    res_w.m20 = sat_f(rnd_f(t3_q[2]));
    res_w.m01 = sat_f(rnd_f(t3_q[3]));
    res_w.m11 = sat_f(rnd_f(t3_q[4]));
    res_w.m21 = sat_f(rnd_f(t3_q[5]));
    res_w.m02 = sat_f(rnd_f(t3_q[6]));
    res_w.m12 = sat_f(rnd_f(t3_q[7]));
    res_w.m22 = sat_f(rnd_f(t3_q[8]));
  end

  // Result queue
  assign wr_en    = en_o && v_q[2];
  assign empty    = (cnt_q == 2'd0);
  assign rd_en    = pop && !empty;
  assign result_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_q <= ~wr_q;
      end
      if (rd_en) begin
        rd_q <= ~rd_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!wr_en && rd_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_w;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(ODepth))
    else $error("result queue count out of range");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_o && v_q[2] |=> v_q[2])
    else $error("result dropped while queue full");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_q == rd_q))
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hdl/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix, Rodrigues' formula, top level.
// Depends on aarm_pkg, aarm_front, aarm_cordic and aarm_matrix.
//
// Push a unit axis (Q1.14) and an angle in 1/64 degree; pop the nine matrix
// entries in column-major order, Q1.14, saturated to 16 bits. The block takes
// one item per clock and returns one result per clock when pop keeps up.
// From the accepting edge to the result showing at the output, an item passes
// the front queue, the CORDIC pipeline (angle scaling, 24 rotation stages,
// quadrant fold) and the product and rounding stages, the last of which
// writes a two-entry result queue. When that queue fills, the whole back
// pipeline holds; the four-entry front queue then absorbs further pushes
// before full rises. No state carries from one item to the next.
`default_nettype none

module axis_angle_rotation_matrix import aarm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  output logic         full,
  input  wire item_t   item_i,
  output logic         empty,
  input  wire logic    pop,
  output result_t      result_o
);

  logic   en;
  logic   fq_valid;
  entry_t fq_entry;
  logic   cs_valid;
  cs_t    cs;

  aarm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .take_i  (en),
    .valid_o (fq_valid),
    .entry_o (fq_entry)
  );

  aarm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fq_valid),
    .entry_i (fq_entry),
    .valid_o (cs_valid),
    .cs_o    (cs)
  );

  aarm_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cs_valid),
    .cs_i     (cs),
    .en_o     (en),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
